// ===== rtl/core/rmq_pkg.sv =====
// ============================================================================
// rmq_pkg: shared definitions for the rotation-matrix-to-quaternion unit
// Default number format, register reset value and pivot branch codes.
// ============================================================================
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 18;

  localparam int              EPS_BITS  = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

  // Component that carries the square root in the chosen branch
  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } pivot_t;

endpackage

// ===== rtl/core/rmq_sqrt.sv =====
// ============================================================================
// rmq_sqrt: pipelined integer square root
// Restoring square root, one result bit per stage; floor(sqrt(x)).
// ============================================================================
module rmq_sqrt #(
  parameter int XB = 36
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XB-1:0]   x,
  output logic [XB/2-1:0] root
);

  localparam int RB = XB / 2;

  logic [XB-1:0] x_r    [RB+1];
  logic [RB:0]   rem_r  [RB+1];
  logic [RB-1:0] root_r [RB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= RB; k++) begin : g_step
    logic [RB+2:0] sh;
    logic [RB+2:0] trial;
    logic          ge;

    always_comb begin
      sh    = {rem_r[k-1], x_r[k-1][XB-1:XB-2]};
      trial = (RB+3)'({root_r[k-1], 2'b01});
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_r[k-1] << 2;
        rem_r[k]  <= ge ? (RB+1)'(sh - trial) : (RB+1)'(sh);
        root_r[k] <= {root_r[k-1][RB-2:0], ge};
      end
    end
  end

  assign root = root_r[RB];

endmodule

// ===== rtl/core/rmq_div.sv =====
// ============================================================================
// rmq_div: pipelined restoring divider with quotient overflow flag
// floor(num/den) in QB bits, one bit per stage; sat marks a larger quotient.
// ============================================================================
module rmq_div #(
  parameter int NB = 35,
  parameter int DB = 18,
  parameter int QB = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic [QB-1:0] quo,
  output logic          sat
);

  localparam int HB = NB - QB;
  localparam int CB = (HB > DB) ? HB : DB;

  logic [DB-1:0] rem_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [DB-1:0] den_r [QB+1];
  logic          sat_r [QB+1];

  logic [HB-1:0] hi;
  assign hi = num[NB-1:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DB'(hi);
      low_r[0] <= num[QB-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      sat_r[0] <= (CB'(hi) >= CB'(den));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DB:0] sh;
    logic [DB:0] dx;
    logic        ge;

    always_comb begin
      sh = {rem_r[k-1], low_r[k-1][QB-1]};
      dx = {1'b0, den_r[k-1]};
      ge = (sh >= dx);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DB'(sh - dx) : DB'(sh);
        low_r[k] <= low_r[k-1] << 1;
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
        den_r[k] <= den_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign quo = quo_r[QB];
  assign sat = sat_r[QB];

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion_unit.sv =====
// ============================================================================
// rotation_matrix_to_quaternion_unit: rotation matrix to unit quaternion
// Four-branch trace method with pipelined square roots and dividers, then
// normalization by the quaternion length when it exceeds norm_epsilon.
// ============================================================================
// The unit takes one request per clock unless the pipe is stalled. Requests pass
// through two bit-serial square roots and two ranks of restoring dividers, one
// result bit per stage each; the default number format is Q1.16 in 18 bits. The
// whole pipe advances together: when a finished result is held at the output,
// input requests stall until it is taken. norm_epsilon may be written only while
// no request is in flight. A non-positive radicand returns zero components with
// degenerate set; all components saturate to the signed word range.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [rmq_pkg::EPS_BITS-1:0]     cfg_write_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [WORD_BITS-1:0]      entry_0,
  input  logic signed [WORD_BITS-1:0]      entry_1,
  input  logic signed [WORD_BITS-1:0]      entry_2,
  input  logic signed [WORD_BITS-1:0]      entry_4,
  input  logic signed [WORD_BITS-1:0]      entry_5,
  input  logic signed [WORD_BITS-1:0]      entry_6,
  input  logic signed [WORD_BITS-1:0]      entry_8,
  input  logic signed [WORD_BITS-1:0]      entry_9,
  input  logic signed [WORD_BITS-1:0]      entry_10,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [WORD_BITS-1:0]      quat_x,
  output logic signed [WORD_BITS-1:0]      quat_y,
  output logic signed [WORD_BITS-1:0]      quat_z,
  output logic signed [WORD_BITS-1:0]      quat_w,
  output logic                             degenerate
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = W + 1;
  // signed width that holds trace + one and every radicand
  localparam int RSW = ((W > F) ? W : F + 1) + 3;
  localparam int SQI = RSW - 1 + F;
  localparam int SQX = SQI + (SQI % 2);
  localparam int SQB = SQX / 2;
  localparam int SQ1L = SQB + 1;
  localparam int SQ2X = 2 * W + 2;
  localparam int SQ2L = W + 2;
  localparam int DVL  = W + 1;
  localparam int NB1  = DW + F;
  localparam int NB2  = W + F + 1;
  localparam int PCW  = (SQB + 1 > W) ? SQB + 1 : W;
  localparam int ECW  = (W + 1 > rmq_pkg::EPS_BITS) ? W + 1 : rmq_pkg::EPS_BITS;
  localparam int SEGC = 3 + SQ2L;
  localparam int LAT  = SQB + 3 * W + 11;

  localparam logic signed [RSW-1:0] ONE  = RSW'(1) << F;
  localparam logic signed [W-1:0]   WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    rmq_pkg::pivot_t      piv;
    logic                 degen;
  } side_a_t;

  typedef struct packed {
    logic [SQB-1:0]  h;
    logic [2:0]      neg;
    rmq_pkg::pivot_t piv;
    logic            degen;
  } side_b_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] cz;
    logic signed [W-1:0] cw;
    logic                degen;
  } side_c_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] cz;
    logic signed [W-1:0] cw;
    logic [3:0]          neg;
    logic                norm;
    logic                degen;
  } side_d_t;

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [W-1:0] mag_c(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // round half away from zero from a doubled quotient, then saturate
  function automatic logic signed [W-1:0] round_q(input logic [W-1:0] q,
                                                  input logic sat,
                                                  input logic neg);
    logic [W:0]   rq;
    logic [W-1:0] m;
    rq = ({1'b0, q} + (W+1)'(1)) >> 1;
    m  = rq[W-1:0];
    if (sat) begin
      return neg ? WMIN : WMAX;
    end
    if (neg) begin
      return $signed(W'(~m + W'(1)));
    end
    return rq[W-1] ? WMAX : $signed(m);
  endfunction

  // --------------------------------------------------------------------------
  // Pipe control: every stage advances together
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic [rmq_pkg::EPS_BITS-1:0] norm_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_epsilon <= rmq_pkg::EPS_RESET;
    end else if (cfg_write_en) begin
      norm_epsilon <= cfg_write_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: trace, branch choice, radicand and the three Shepperd terms
  // --------------------------------------------------------------------------
  logic signed [RSW-1:0] e0, e1, e2, e4, e5, e6, e8, e9, e10;
  logic signed [RSW-1:0] trace, rad;
  side_a_t               s1_next;

  assign e0  = RSW'(entry_0);
  assign e1  = RSW'(entry_1);
  assign e2  = RSW'(entry_2);
  assign e4  = RSW'(entry_4);
  assign e5  = RSW'(entry_5);
  assign e6  = RSW'(entry_6);
  assign e8  = RSW'(entry_8);
  assign e9  = RSW'(entry_9);
  assign e10 = RSW'(entry_10);
  assign trace = e0 + e5 + e10;

  always_comb begin
    s1_next = '0;
    rad     = '0;
    priority if (trace > 0) begin
      s1_next.piv = rmq_pkg::PIV_W;
      rad         = trace + ONE;
      s1_next.d0  = DW'(e9 - e6);
      s1_next.d1  = DW'(e2 - e8);
      s1_next.d2  = DW'(e4 - e1);
    end else if (e0 > e5 && e0 > e10) begin
      s1_next.piv = rmq_pkg::PIV_X;
      rad         = ONE + e0 - e5 - e10;
      s1_next.d0  = DW'(e9 - e6);
      s1_next.d1  = DW'(e1 + e4);
      s1_next.d2  = DW'(e2 + e8);
    end else if (e5 > e10) begin
      s1_next.piv = rmq_pkg::PIV_Y;
      rad         = ONE + e5 - e0 - e10;
      s1_next.d0  = DW'(e2 - e8);
      s1_next.d1  = DW'(e1 + e4);
      s1_next.d2  = DW'(e6 + e9);
    end else begin
      s1_next.piv = rmq_pkg::PIV_Z;
      rad         = ONE + e10 - e0 - e5;
      s1_next.d0  = DW'(e4 - e1);
      s1_next.d1  = DW'(e2 + e8);
      s1_next.d2  = DW'(e6 + e9);
    end
    s1_next.degen = (rad <= 0);
  end

  side_a_t          s1;
  logic [RSW-2:0]   s1_rad;

  always_ff @(posedge clk) begin
    if (en) begin
      s1     <= s1_next;
      s1_rad <= rad[RSW-2:0];
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the scaled radicand; hold the terms alongside
  // --------------------------------------------------------------------------
  logic [SQX-1:0] sq1_x;
  logic [SQB-1:0] h;

  assign sq1_x = s1.degen ? '0 : (SQX'(s1_rad) << F);

  rmq_sqrt #(.XB(SQX)) u_sqrt_piv (
    .clk  (clk),
    .en   (en),
    .x    (sq1_x),
    .root (h)
  );

  side_a_t seg_a [SQ1L];

  always_ff @(posedge clk) begin
    if (en) begin
      seg_a[0] <= s1;
      for (int i = 1; i < SQ1L; i++) begin
        seg_a[i] <= seg_a[i-1];
      end
    end
  end

  side_a_t              a_o;
  logic signed [DW-1:0] a_d [3];

  assign a_o    = seg_a[SQ1L-1];
  assign a_d[0] = a_o.d0;
  assign a_d[1] = a_o.d1;
  assign a_d[2] = a_o.d2;

  // --------------------------------------------------------------------------
  // Divide each term by h for the three non-pivot components
  // --------------------------------------------------------------------------
  logic [W-1:0] q1 [3];
  logic         q1_sat [3];

  for (genvar g = 0; g < 3; g++) begin : g_div1
    logic [NB1-1:0] num;
    assign num = NB1'(mag_d(a_d[g])) << F;

    rmq_div #(.NB(NB1), .DB(SQB), .QB(W)) u_div (
      .clk (clk),
      .en  (en),
      .num (num),
      .den (h),
      .quo (q1[g]),
      .sat (q1_sat[g])
    );
  end

  side_b_t b_in;
  side_b_t seg_b [DVL];

  always_comb begin
    b_in.h     = h;
    b_in.neg   = {a_d[2][DW-1], a_d[1][DW-1], a_d[0][DW-1]};
    b_in.piv   = a_o.piv;
    b_in.degen = a_o.degen;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_b[0] <= b_in;
      for (int i = 1; i < DVL; i++) begin
        seg_b[i] <= seg_b[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: round, saturate and place the four components
  // --------------------------------------------------------------------------
  side_b_t             b_o;
  logic [SQB:0]        hp;
  logic [PCW-1:0]      hp_ext;
  logic signed [W-1:0] pv;
  logic signed [W-1:0] rq [3];
  side_c_t             s3_next;

  assign b_o    = seg_b[DVL-1];
  assign hp     = ({1'b0, b_o.h} + (SQB+1)'(1)) >> 1;
  assign hp_ext = PCW'(hp);
  assign pv     = (hp_ext > PCW'(WMAX)) ? WMAX : $signed(hp_ext[W-1:0]);

  for (genvar g = 0; g < 3; g++) begin : g_rnd1
    assign rq[g] = round_q(q1[g], q1_sat[g], b_o.neg[g]);
  end

  always_comb begin
    s3_next.degen = b_o.degen;
    unique case (b_o.piv)
      rmq_pkg::PIV_W: begin
        s3_next.cx = rq[0]; s3_next.cy = rq[1]; s3_next.cz = rq[2]; s3_next.cw = pv;
      end
      rmq_pkg::PIV_X: begin
        s3_next.cx = pv; s3_next.cy = rq[1]; s3_next.cz = rq[2]; s3_next.cw = rq[0];
      end
      rmq_pkg::PIV_Y: begin
        s3_next.cx = rq[1]; s3_next.cy = pv; s3_next.cz = rq[2]; s3_next.cw = rq[0];
      end
      default: begin
        s3_next.cx = rq[1]; s3_next.cy = rq[2]; s3_next.cz = pv; s3_next.cw = rq[0];
      end
    endcase
  end

  side_c_t s3;

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s3_next;
    end
  end

  // --------------------------------------------------------------------------
  // Squared length: squares, pair sums, total
  // --------------------------------------------------------------------------
  logic [2*W-1:0]  sq [4];
  logic [2*W:0]    psum [2];
  logic [SQ2X-1:0] tot;
  logic [W-1:0]    s3_mag [4];

  assign s3_mag[0] = mag_c(s3.cx);
  assign s3_mag[1] = mag_c(s3.cy);
  assign s3_mag[2] = mag_c(s3.cz);
  assign s3_mag[3] = mag_c(s3.cw);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq[i] <= s3_mag[i] * s3_mag[i];
      end
      psum[0] <= (2*W+1)'(sq[0]) + (2*W+1)'(sq[1]);
      psum[1] <= (2*W+1)'(sq[2]) + (2*W+1)'(sq[3]);
      tot     <= SQ2X'(psum[0]) + SQ2X'(psum[1]);
    end
  end

  logic [W:0] len;

  rmq_sqrt #(.XB(SQ2X)) u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .x    (tot),
    .root (len)
  );

  side_c_t seg_c [SEGC];

  always_ff @(posedge clk) begin
    if (en) begin
      seg_c[0] <= s3;
      for (int i = 1; i < SEGC; i++) begin
        seg_c[i] <= seg_c[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normalize: divide each component by the length
  // --------------------------------------------------------------------------
  side_c_t             c_o;
  logic signed [W-1:0] c_arr [4];
  logic [W-1:0]        q2 [4];
  logic                q2_sat [4];
  side_d_t             d_in;

  assign c_o      = seg_c[SEGC-1];
  assign c_arr[0] = c_o.cx;
  assign c_arr[1] = c_o.cy;
  assign c_arr[2] = c_o.cz;
  assign c_arr[3] = c_o.cw;

  for (genvar g = 0; g < 4; g++) begin : g_div2
    logic [NB2-1:0] num;
    assign num = NB2'(mag_c(c_arr[g])) << (F + 1);

    rmq_div #(.NB(NB2), .DB(W+1), .QB(W)) u_div (
      .clk (clk),
      .en  (en),
      .num (num),
      .den (len),
      .quo (q2[g]),
      .sat (q2_sat[g])
    );
  end

  always_comb begin
    d_in.cx    = c_o.cx;
    d_in.cy    = c_o.cy;
    d_in.cz    = c_o.cz;
    d_in.cw    = c_o.cw;
    d_in.neg   = {c_o.cw[W-1], c_o.cz[W-1], c_o.cy[W-1], c_o.cx[W-1]};
    d_in.norm  = (ECW'(len) > ECW'(norm_epsilon));
    d_in.degen = c_o.degen;
  end

  side_d_t seg_d [DVL];

  always_ff @(posedge clk) begin
    if (en) begin
      seg_d[0] <= d_in;
      for (int i = 1; i < DVL; i++) begin
        seg_d[i] <= seg_d[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick normalized or raw components, zero when degenerate
  // --------------------------------------------------------------------------
  side_d_t             d_o;
  logic signed [W-1:0] nq [4];
  logic signed [W-1:0] fin [4];

  assign d_o = seg_d[DVL-1];

  for (genvar g = 0; g < 4; g++) begin : g_rnd2
    assign nq[g] = round_q(q2[g], q2_sat[g], d_o.neg[g]);
  end

  always_comb begin
    priority if (d_o.degen) begin
      for (int i = 0; i < 4; i++) fin[i] = '0;
    end else if (d_o.norm) begin
      for (int i = 0; i < 4; i++) fin[i] = nq[i];
    end else begin
      fin[0] = d_o.cx;
      fin[1] = d_o.cy;
      fin[2] = d_o.cz;
      fin[3] = d_o.cw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_x     <= fin[0];
      quat_y     <= fin[1];
      quat_z     <= fin[2];
      quat_w     <= fin[3];
      degenerate <= d_o.degen;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
    else $error("degenerate result with nonzero components");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output held");

  a_eps_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_write_en) |-> $stable(norm_epsilon))
    else $error("norm_epsilon changed without a write");

endmodule
